// ----- sv/spike_bin_zscore_detector_defines.svh -----
// Assertion macros for the spike bin z-score detector.
// Depends on nothing; included by the modules that check themselves.
`ifndef SPIKE_BIN_ZSCORE_DETECTOR_DEFINES_SVH
`define SPIKE_BIN_ZSCORE_DETECTOR_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define SBZ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define SBZ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/sbz_pkg.sv -----
// Shared types and constants of the spike bin z-score detector.
// Depends on nothing.
package sbz_pkg;

    localparam int RING_BINS_DEF  = 64;
    localparam int COUNT_BITS_DEF = 16;

    localparam logic [1:0] ACT_SPIKE   = 2'd0;
    localparam logic [1:0] ACT_BIN_END = 2'd1;
    localparam logic [1:0] ACT_MANUAL  = 2'd2;

    localparam logic [1:0] CFG_BIN_SAMPLES = 2'd0;
    localparam logic [1:0] CFG_TRIGGER     = 2'd1;
    localparam logic [1:0] CFG_BINS_NEEDED = 2'd2;

    localparam logic [23:0] BIN_SAMPLES_RST = 24'd1500;
    localparam logic [15:0] TRIGGER_RST     = 16'd256;
    localparam logic [19:0] BINS_NEEDED_RST = 20'd200;

    localparam logic [31:0] ONE_Q16        = 32'h0001_0000;
    localparam logic [19:0] BINS_SEEN_MAX  = 20'hFFFFF;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
    } t_div_rsp;

endpackage

// ----- sv/sbz_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
// Also tracks the quotient modulo RING_BINS. Depends on sbz_pkg.
module sbz_div
    import sbz_pkg::*;
#(
    parameter int RING_BINS = RING_BINS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_div_req                     i_req,
    output t_div_rsp                     o_rsp,
    output logic [$clog2(RING_BINS)-1:0] o_mod
);
    localparam int MW = $clog2(RING_BINS);
    localparam logic [MW:0] RB = (MW+1)'(RING_BINS);
    localparam logic [5:0] LAST = 6'd63;

    logic          r_busy;
    logic          r_done;
    logic [5:0]    r_cnt;
    logic [63:0]   r_quo;
    logic [31:0]   r_rem;
    logic [31:0]   r_div;
    logic [MW-1:0] r_mod;

    logic [32:0]   w_shift;
    logic          w_ge;
    logic [32:0]   w_rem;
    logic [MW:0]   w_mt;
    logic [MW:0]   w_mn;

    always_comb begin
        w_shift = {r_rem, r_quo[63]};
        w_ge    = w_shift >= {1'b0, r_div};
        w_rem   = w_ge ? (w_shift - {1'b0, r_div}) : w_shift;
        w_mt    = {r_mod, w_ge};
        w_mn    = (w_mt >= RB) ? (w_mt - RB) : w_mt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
            r_mod <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[62:0], w_ge};
            r_rem <= w_rem[31:0];
            r_mod <= w_mn[MW-1:0];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_mod      = r_mod;

endmodule

// ----- sv/sbz_isqrt.sv -----
// Digit-by-digit integer square root, two radicand bits per cycle.
// Depends on nothing.
module sbz_isqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_value,
    output logic        o_done,
    output logic [31:0] o_root
);
    localparam logic [4:0] LAST = 5'd31;

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [63:0] r_val;
    logic [34:0] r_rem;
    logic [31:0] r_root;

    logic [34:0] w_rs;
    logic [34:0] w_trial;
    logic        w_ge;

    always_comb begin
        w_rs    = {r_rem[32:0], r_val[63:62]};
        w_trial = {1'b0, r_root, 2'b01};
        w_ge    = w_rs >= w_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= i_value;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_val  <= {r_val[61:0], 2'b00};
            r_rem  <= w_ge ? (w_rs - w_trial) : w_rs;
            r_root <= {r_root[30:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ----- sv/sbz_ring.sv -----
// Ring of per-bin spike counters in one synchronous memory with a registered read port.
// Sweeps zero through every entry after reset. Depends on nothing.
module sbz_ring #(
    parameter int RING_BINS  = 64,
    parameter int COUNT_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_rd_en,
    input  logic [$clog2(RING_BINS)-1:0] i_rd_addr,
    output logic [COUNT_BITS-1:0]        o_rd_data,
    input  logic                         i_wr_en,
    input  logic [$clog2(RING_BINS)-1:0] i_wr_addr,
    input  logic [COUNT_BITS-1:0]        i_wr_data,
    output logic                         o_clearing
);
    localparam int AW = $clog2(RING_BINS);
    localparam logic [AW-1:0] LAST = AW'(RING_BINS - 1);

    logic [COUNT_BITS-1:0] mem [RING_BINS];
    logic [COUNT_BITS-1:0] r_rd_data;
    logic                  r_clearing;
    logic [AW-1:0]         r_clr_addr;

    logic                  w_we;
    logic [AW-1:0]         w_wa;
    logic [COUNT_BITS-1:0] w_wd;

    always_comb begin
        w_we = r_clearing | i_wr_en;
        w_wa = r_clearing ? r_clr_addr : i_wr_addr;
        w_wd = r_clearing ? '0 : i_wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == LAST) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_wa] <= w_wd;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_clearing = r_clearing;

endmodule

// ----- sv/spike_bin_zscore_detector.sv -----
// Channel  | handshake                 | payload
// input    | i_in_valid / o_in_ready   | i_action i_sample_time i_manual_mean i_manual_sd
// result   | o_out_valid / i_out_ready | o_z_value o_direction o_bin_count o_frozen
// config   | i_cfg_valid / o_cfg_ready | i_cfg_index i_cfg_data
// One word at a time. Spike: the shared divider finds the bin index, then the counter
// read-modify-write. Bin end: two divides when frozen; while learning, up to three
// divides and a square root. Manual baseline: taken without leaving idle.
// Synchronous reset, then the counter memory is cleared before the first word is
// taken; a waiting result holds the next bin end in its last step, which stalls input.
// Registers are taken only when idle.
// Top level; depends on sbz_pkg, sbz_div, sbz_isqrt, sbz_ring and the defines header.
`include "spike_bin_zscore_detector_defines.svh"
module spike_bin_zscore_detector
    import sbz_pkg::*;
#(
    parameter int RING_BINS  = RING_BINS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_action,
    input  logic [47:0]        i_sample_time,
    input  logic [31:0]        i_manual_mean,
    input  logic [31:0]        i_manual_sd,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_z_value,
    output logic signed [1:0]  o_direction,
    output logic [15:0]        o_bin_count,
    output logic               o_frozen,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data
);
    localparam int AW = $clog2(RING_BINS);
    localparam logic [AW-1:0] SLOT_LAST = AW'(RING_BINS - 1);

    typedef enum logic [10:0] {
        S_CLEAR = 11'b000_0000_0001,
        S_IDLE  = 11'b000_0000_0010,
        S_DIVT  = 11'b000_0000_0100,
        S_MOD   = 11'b000_0000_1000,
        S_LDIV  = 11'b000_0001_0000,
        S_LMUL  = 11'b000_0010_0000,
        S_LACC  = 11'b000_0100_0000,
        S_LVAR  = 11'b000_1000_0000,
        S_LSQRT = 11'b001_0000_0000,
        S_ZDIV  = 11'b010_0000_0000,
        S_OUT   = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;

    logic [23:0] r_bin_samples;
    logic [15:0] r_trigger;
    logic [19:0] r_bins_needed;

    logic [1:0]  r_action;
    logic [AW-1:0] r_slot;
    logic [15:0] r_count;
    logic        r_was_frozen;
    logic [19:0] r_bins_seen;
    logic [31:0] r_mean;
    logic [63:0] r_m2;
    logic [31:0] r_bmean;
    logic [31:0] r_bsd;
    logic        r_frozen;
    logic        r_manual;
    logic        r_neg;
    logic [31:0] r_m1;
    logic [63:0] r_prod;
    logic [47:0] r_mag;
    logic [55:0] r_thr;
    logic [31:0] r_res_z;
    logic [1:0]  r_res_dir;

    logic        r_out_valid;
    logic [31:0] r_out_z;
    logic [1:0]  r_out_dir;
    logic [15:0] r_out_cnt;
    logic        r_out_frz;

    t_div_req      w_div_req;
    t_div_rsp      w_div_rsp;
    logic [AW-1:0] w_div_mod;
    logic          w_sq_start;
    logic [63:0]   w_sq_value;
    logic          w_sq_done;
    logic [31:0]   w_sq_root;

    logic                  w_rd_en;
    logic [AW-1:0]         w_rd_addr;
    logic [COUNT_BITS-1:0] w_rd_data;
    logic                  w_wr_en;
    logic [COUNT_BITS-1:0] w_wr_data;
    logic                  w_clearing;

    logic          w_in_acc;
    logic          w_out_free;
    logic [23:0]   w_bs;
    logic [19:0]   w_need;
    logic [31:0]   w_ext;
    logic [15:0]   w_cnt;
    logic [19:0]   w_seen;
    logic [33:0]   w_x;
    logic [33:0]   w_delta;
    logic [31:0]   w_dabs;
    logic [33:0]   w_delta2;
    logic [31:0]   w_d2abs;
    logic [33:0]   w_num;
    logic [31:0]   w_nabs;
    logic [64:0]   w_sum;
    logic [63:0]   w_m2_new;
    logic [31:0]   w_zsat;
    logic [31:0]   w_sd_root;

    always_comb begin
        w_in_acc   = i_in_valid && o_in_ready;
        w_out_free = !r_out_valid || i_out_ready;
        w_bs       = (r_bin_samples == '0) ? 24'd1 : r_bin_samples;
        w_need     = (r_bins_needed == '0) ? 20'd1 : r_bins_needed;
        w_ext      = 32'(w_rd_data);
        w_cnt      = (w_ext > 32'h0000_FFFF) ? 16'hFFFF : w_ext[15:0];
        w_seen     = (r_bins_seen < BINS_SEEN_MAX) ? (r_bins_seen + 20'd1) : r_bins_seen;
        w_x        = {2'b00, w_cnt, 16'h0000};
        w_delta    = w_x - {2'b00, r_mean};
        w_dabs     = w_delta[33] ? 32'(-w_delta) : w_delta[31:0];
        w_num      = w_x - {2'b00, r_bmean};
        w_nabs     = w_num[33] ? 32'(-w_num) : w_num[31:0];
        w_delta2   = {2'b00, r_count, 16'h0000} - {2'b00, r_mean};
        w_d2abs    = w_delta2[33] ? 32'(-w_delta2) : w_delta2[31:0];
        w_sum      = {1'b0, r_m2} + {17'b0, r_prod[63:16]};
        w_m2_new   = w_sum[64] ? '1 : w_sum[63:0];
        w_sd_root  = (w_sq_root == '0) ? ONE_Q16 : w_sq_root;
        if (r_neg) begin
            w_zsat = (w_div_rsp.quo > 64'h8000_0000) ? 32'h8000_0000
                                                     : 32'(-w_div_rsp.quo[31:0]);
        end else begin
            w_zsat = (w_div_rsp.quo > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF
                                                     : w_div_rsp.quo[31:0];
        end
    end

    always_comb begin
        n_state            = r_state;
        w_div_req.start    = 1'b0;
        w_div_req.dividend = '0;
        w_div_req.divisor  = '0;
        w_sq_start         = 1'b0;
        w_sq_value         = {w_div_rsp.quo[47:0], 16'h0000};
        w_rd_en            = 1'b0;
        w_rd_addr          = (r_action == ACT_SPIKE) ? w_div_mod
                           : ((w_div_mod == '0) ? SLOT_LAST : (w_div_mod - 1'b1));
        w_wr_en            = 1'b0;
        w_wr_data          = '0;
        case (r_state)
            S_CLEAR: begin
                if (!w_clearing) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_in_acc && (i_action == ACT_SPIKE || i_action == ACT_BIN_END)) begin
                    w_div_req.start    = 1'b1;
                    w_div_req.dividend = {16'h0000, i_sample_time};
                    w_div_req.divisor  = {8'h00, w_bs};
                    n_state            = S_DIVT;
                end
            end
            S_DIVT: begin
                if (w_div_rsp.done) begin
                    w_rd_en = 1'b1;
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                w_wr_en = 1'b1;
                if (r_action == ACT_SPIKE) begin
                    w_wr_data = (w_rd_data == '1) ? w_rd_data : (w_rd_data + 1'b1);
                    n_state   = S_IDLE;
                end else if (r_frozen) begin
                    if (r_bsd == '0) begin
                        n_state = S_OUT;
                    end else begin
                        w_div_req.start    = 1'b1;
                        w_div_req.dividend = {16'h0000, w_nabs, 16'h0000};
                        w_div_req.divisor  = r_bsd;
                        n_state            = S_ZDIV;
                    end
                end else begin
                    w_div_req.start    = 1'b1;
                    w_div_req.dividend = {32'h0, w_dabs};
                    w_div_req.divisor  = {12'h000, w_seen};
                    n_state            = S_LDIV;
                end
            end
            S_LDIV: begin
                if (w_div_rsp.done) begin
                    n_state = S_LMUL;
                end
            end
            S_LMUL: begin
                n_state = S_LACC;
            end
            S_LACC: begin
                if (r_bins_seen >= w_need && r_bins_seen > 20'd1) begin
                    w_div_req.start    = 1'b1;
                    w_div_req.dividend = w_m2_new;
                    w_div_req.divisor  = {12'h000, r_bins_seen - 20'd1};
                    n_state            = S_LVAR;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_LVAR: begin
                if (w_div_rsp.done) begin
                    if (w_div_rsp.quo[63:48] != '0) begin
                        n_state = S_OUT;
                    end else begin
                        w_sq_start = 1'b1;
                        n_state    = S_LSQRT;
                    end
                end
            end
            S_LSQRT: begin
                if (w_sq_done) begin
                    n_state = S_OUT;
                end
            end
            S_ZDIV: begin
                if (w_div_rsp.done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_bin_samples <= BIN_SAMPLES_RST;
            r_trigger     <= TRIGGER_RST;
            r_bins_needed <= BINS_NEEDED_RST;
            r_bins_seen   <= '0;
            r_mean        <= '0;
            r_m2          <= '0;
            r_bmean       <= '0;
            r_bsd         <= '0;
            r_frozen      <= 1'b0;
            r_manual      <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_BIN_SAMPLES: r_bin_samples <= i_cfg_data;
                    CFG_TRIGGER:     r_trigger     <= i_cfg_data[15:0];
                    CFG_BINS_NEEDED: r_bins_needed <= i_cfg_data[19:0];
                    default: ;
                endcase
            end
            if (w_in_acc && i_action == ACT_MANUAL && !r_manual && i_manual_sd != '0) begin
                r_bmean  <= i_manual_mean;
                r_bsd    <= i_manual_sd;
                r_frozen <= 1'b1;
                r_manual <= 1'b1;
            end
            if (r_state == S_MOD && r_action == ACT_BIN_END && !r_frozen) begin
                r_bins_seen <= w_seen;
            end
            if (r_state == S_LDIV && w_div_rsp.done) begin
                r_mean <= r_neg ? (r_mean - w_div_rsp.quo[31:0])
                                : (r_mean + w_div_rsp.quo[31:0]);
            end
            if (r_state == S_LACC) begin
                r_m2 <= w_m2_new;
                if (r_bins_seen >= w_need && r_bins_seen <= 20'd1) begin
                    r_bmean  <= r_mean;
                    r_bsd    <= ONE_Q16;
                    r_frozen <= 1'b1;
                end
            end
            if (r_state == S_LVAR && w_div_rsp.done && w_div_rsp.quo[63:48] != '0) begin
                r_bmean  <= r_mean;
                r_bsd    <= 32'hFFFF_FFFF;
                r_frozen <= 1'b1;
            end
            if (r_state == S_LSQRT && w_sq_done) begin
                r_bmean  <= r_mean;
                r_bsd    <= w_sd_root;
                r_frozen <= 1'b1;
            end
            if (r_state == S_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_action <= i_action;
        end
        if (r_state == S_DIVT && w_div_rsp.done) begin
            r_slot <= w_rd_addr;
        end
        if (r_state == S_MOD) begin
            r_count      <= w_cnt;
            r_was_frozen <= r_frozen;
            r_res_z      <= '0;
            r_res_dir    <= '0;
            r_neg        <= r_frozen ? w_num[33] : w_delta[33];
            r_m1         <= w_dabs;
            r_mag        <= {w_nabs, 16'h0000};
            r_thr        <= {r_trigger, 8'h00} * r_bsd;
        end
        if (r_state == S_LMUL) begin
            r_prod <= r_m1 * w_d2abs;
        end
        if (r_state == S_ZDIV && w_div_rsp.done) begin
            r_res_z <= w_zsat;
            if ({8'h00, r_mag} > r_thr) begin
                r_res_dir <= r_neg ? 2'b11 : 2'b01;
            end
        end
        if (r_state == S_OUT && w_out_free) begin
            r_out_z   <= r_res_z;
            r_out_dir <= r_res_dir;
            r_out_cnt <= r_count;
            r_out_frz <= r_was_frozen;
        end
    end

    sbz_div #(
        .RING_BINS(RING_BINS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp),
        .o_mod   (w_div_mod)
    );

    sbz_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_value (w_sq_value),
        .o_done  (w_sq_done),
        .o_root  (w_sq_root)
    );

    sbz_ring #(
        .RING_BINS  (RING_BINS),
        .COUNT_BITS (COUNT_BITS)
    ) u_ring (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (w_rd_en),
        .i_rd_addr  (w_rd_addr),
        .o_rd_data  (w_rd_data),
        .i_wr_en    (w_wr_en),
        .i_wr_addr  (r_slot),
        .i_wr_data  (w_wr_data),
        .o_clearing (w_clearing)
    );

    assign o_in_ready  = (r_state == S_IDLE) && !i_cfg_valid;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_z_value   = r_out_z;
    assign o_direction = r_out_dir;
    assign o_bin_count = r_out_cnt;
    assign o_frozen    = r_out_frz;

    `SBZ_ASSERT(a_div_done_awaited, i_clk, i_rst_n, !w_div_rsp.done || r_state == S_DIVT || r_state == S_LDIV || r_state == S_LVAR || r_state == S_ZDIV, "divider finished with nobody waiting")
    `SBZ_ASSERT(a_frozen_sticks, i_clk, i_rst_n, !$fell(r_frozen), "baseline unfroze")
    `SBZ_ASSERT_NEXT(a_spike_no_result, i_clk, i_rst_n, r_state == S_MOD && r_action == ACT_SPIKE, r_state == S_IDLE, "spike word did not return to idle")
    `SBZ_ASSERT(a_learning_zero, i_clk, i_rst_n, !o_out_valid || o_frozen || (o_z_value == 0 && o_direction == 0), "nonzero z while learning")

endmodule
